// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KCIT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define KCIT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KCIT_ASSERT_NOW(label, ante, cons)
`define KCIT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/kcit_pkg.sv =====
// Package with the types and constants of the keyed content index table.
`default_nettype none
package kcit_pkg;
	localparam int DEPTH = 32;
	localparam int NAME_BYTES = 8;
	localparam int LOC_BITS = 64;
	localparam int FIELD_W = 64;
	localparam int NAME_W = 8 * NAME_BYTES;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = 2 * NAME_W + LOC_BITS;

	typedef enum logic [1:0] {
		CMD_REG    = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DEREG  = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_REGISTERED = 3'd0,
		ST_DUPLICATE  = 3'd1,
		ST_FULL       = 3'd2,
		ST_FOUND      = 3'd3,
		ST_NOT_FOUND  = 3'd4,
		ST_REMOVED    = 3'd5,
		ST_LIST_ENTRY = 3'd6,
		ST_LIST_EMPTY = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_LREAD,
		S_LOUT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [NAME_W-1:0]   content;
		logic [NAME_W-1:0]   peer;
		logic [LOC_BITS-1:0] locator;
	} entry_t;

	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] content;
		logic [FIELD_W-1:0] peer;
		logic [FIELD_W-1:0] locator;
		logic               last;
	} result_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} ctrl_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/kcit_if.sv =====
// Command and result channel interfaces of the table.
`default_nettype none
interface kcit_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [63:0] content_key;
	logic [63:0] peer_key;
	logic [63:0] locator_in;
	modport source(output valid, command, content_key, peer_key, locator_in, input ready);
	modport sink(input valid, command, content_key, peer_key, locator_in, output ready);
endinterface

interface kcit_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] content_out;
	logic [63:0] peer_out;
	logic [63:0] locator_out;
	logic        last;
	modport source(output valid, status, content_out, peer_out, locator_out, last, input ready);
	modport sink(input valid, status, content_out, peer_out, locator_out, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kcit_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module kcit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/kcit_out_reg.sv =====
// Output register stage that holds one result until the sink takes it.
`default_nettype none
module kcit_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_vld,
	input  wire kcit_pkg::result_t in_res,
	output logic                   in_rdy,
	kcit_res_if.source             res
);
	import kcit_pkg::*;

	logic    vld_q;
	result_t res_q;

	assign in_rdy = !vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_vld && in_rdy) begin
			vld_q <= 1'b1;
		end else if (res.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld && in_rdy) begin
			res_q <= in_res;
		end
	end

	always_comb begin
		res.valid       = vld_q;
		res.status      = res_q.status;
		res.content_out = res_q.content;
		res.peer_out    = res_q.peer;
		res.locator_out = res_q.locator;
		res.last        = res_q.last;
	end
endmodule
`default_nettype wire

// ===== rtl/core/kcit_ctrl.sv =====
// Command sequencer that scans, shifts and lists the table through the RAM.
`default_nettype none
module kcit_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	kcit_cmd_if.sink                  cmd,
	output kcit_pkg::ram_req_t        ram_req,
	input  wire kcit_pkg::entry_t     ram_rdata,
	output logic                      res_vld,
	output kcit_pkg::result_t         res,
	input  wire logic                 res_rdy,
	output kcit_pkg::ctrl_stat_t      stat
);
	import kcit_pkg::*;

	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [NAME_W-1:0]   key_c_q, key_p_q;
	logic [LOC_BITS-1:0] loc_in_q, loc_q;
	status_t             status_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    idx_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic hit, more, scan_end, issue, list_last, accept;

	assign accept    = cmd.valid && cmd.ready;
	assign more      = idx_q < count_q;
	assign hit       = (state_q == S_SCAN) && vld_s1 && (ram_rdata.content == key_c_q)
		&& (ram_rdata.peer == key_p_q);
	assign scan_end  = !more && !vld_s1;
	assign list_last = (idx_q + CNT_W'(1)) == count_q;
	assign issue     = ((state_q == S_SCAN) && !hit && more) || ((state_q == S_SHIFT) && more)
		|| (state_q == S_LREAD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					if (cmd_t'(cmd.command) == CMD_LIST) begin
						state_d = (count_q == '0) ? S_RESP : S_LREAD;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = (cmd_q == CMD_DEREG) ? S_SHIFT : S_RESP;
				end else if (scan_end) begin
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				if (scan_end) begin
					state_d = S_RESP;
				end
			end
			S_LREAD: state_d = S_LOUT;
			S_LOUT: begin
				if (res_rdy) begin
					state_d = list_last ? S_IDLE : S_LREAD;
				end
			end
			S_RESP: begin
				if (res_rdy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready     = (state_q == S_IDLE);
		res_vld       = (state_q == S_LOUT) || (state_q == S_RESP);
		res.status    = status_q;
		res.content   = '0;
		res.peer      = '0;
		res.locator   = '0;
		res.last      = 1'b1;
		ram_req.re    = issue;
		ram_req.raddr = idx_q[IDX_W-1:0];
		ram_req.we    = 1'b0;
		ram_req.waddr = count_q[IDX_W-1:0];
		ram_req.wdata = '{content: key_c_q, peer: key_p_q, locator: loc_in_q};
		case (state_q)
			S_LOUT: begin
				res.status  = ST_LIST_ENTRY;
				res.content = FIELD_W'(ram_rdata.content);
				res.peer    = FIELD_W'(ram_rdata.peer);
				res.last    = list_last;
			end
			S_RESP: begin
				if (status_q == ST_FOUND) begin
					res.locator = FIELD_W'(loc_q);
				end
				ram_req.we = res_rdy && (status_q == ST_REGISTERED);
			end
			S_SHIFT: begin
				ram_req.we    = vld_s1;
				ram_req.waddr = idx_s1 - IDX_W'(1);
				ram_req.wdata = ram_rdata;
			end
			default: begin
			end
		endcase
		stat.busy  = (state_q != S_IDLE);
		stat.count = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue && (state_q != S_LREAD);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
					end
				end
				S_SCAN: begin
					if (hit) begin
						idx_q <= CNT_W'(idx_s1) + CNT_W'(1);
					end else if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_SHIFT: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_LOUT: begin
					if (res_rdy) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_RESP: begin
					if (res_rdy && (status_q == ST_REGISTERED)) begin
						count_q <= count_q + CNT_W'(1);
					end else if (res_rdy && (status_q == ST_REMOVED)) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
		if (accept) begin
			cmd_q    <= cmd_t'(cmd.command);
			key_c_q  <= cmd.content_key[NAME_W-1:0];
			key_p_q  <= cmd.peer_key[NAME_W-1:0];
			loc_in_q <= cmd.locator_in[LOC_BITS-1:0];
			status_q <= ST_LIST_EMPTY;
		end
		if (hit) begin
			loc_q <= ram_rdata.locator;
			case (cmd_q)
				CMD_REG:    status_q <= ST_DUPLICATE;
				CMD_SEARCH: status_q <= ST_FOUND;
				default:    status_q <= ST_REMOVED;
			endcase
		end else if ((state_q == S_SCAN) && scan_end) begin
			if (cmd_q == CMD_REG) begin
				status_q <= (count_q == CNT_W'(DEPTH)) ? ST_FULL : ST_REGISTERED;
			end else begin
				status_q <= ST_NOT_FOUND;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/keyed_content_index_table_top.sv =====
// Register, search and deregister scan the table one entry per cycle.
// Deregister then moves each later entry down one place, one entry per cycle.
// List gives its entries one at a time, since the sequencer reads the next entry only after
// the current one has moved into the result register.
// One command is worked at a time; the result register frees the sequencer early.
// Reset clears the entry count and the control state; table contents stay undefined.
`default_nettype none
`include "assert_macros.svh"
module keyed_content_index_table_top (
	input wire logic clk,
	input wire logic arst_n,
	kcit_cmd_if.sink   cmd,
	kcit_res_if.source res
);
	import kcit_pkg::*;

	ram_req_t   ram_req;
	entry_t     ram_rdata;
	logic       res_vld, res_rdy;
	result_t    res_d;
	ctrl_stat_t stat;

	kcit_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	kcit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata),
		.res_vld  (res_vld),
		.res      (res_d),
		.res_rdy  (res_rdy),
		.stat     (stat)
	);

	kcit_out_reg u_out_reg (
		.clk   (clk),
		.arst_n(arst_n),
		.in_vld(res_vld),
		.in_res(res_d),
		.in_rdy(res_rdy),
		.res   (res)
	);

	`KCIT_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= CNT_W'(DEPTH))
	`KCIT_ASSERT_NEXT(a_busy_after_cmd, cmd.valid && cmd.ready, stat.busy)
	`KCIT_ASSERT_NEXT(a_reg_grows, res_vld && res_rdy && (res_d.status == ST_REGISTERED),
		stat.count == $past(stat.count) + CNT_W'(1))
	`KCIT_ASSERT_NEXT(a_rem_shrinks, res_vld && res_rdy && (res_d.status == ST_REMOVED),
		stat.count == $past(stat.count) - CNT_W'(1))
endmodule
`default_nettype wire
